FILE: design/ntso_pkg.sv
// Constants and lookup tables for the note-tuned sine oscillator.
// Holds the quarter-wave sine table and the per-note tuning tables.
// No dependencies.
package ntso_pkg;

  localparam int PHASE_W = 18;  // 10 integer bits, 8 fraction bits
  localparam int PINT_W  = 10;  // integer part of the phase
  localparam int FRAC_W  = 8;
  localparam int NOTE_W  = 7;
  localparam int SAMP_W  = 8;
  localparam int MAG_W   = 7;   // quarter-wave magnitudes are 0..127
  localparam int COARSE_W = 11; // coarse steps reach 1027

  localparam logic [SAMP_W-1:0] MIDPOINT = 8'h80;

  localparam logic [MAG_W-1:0] QUARTER_ROM [256] = '{
    7'd0,   7'd1,   7'd2,   7'd2,   7'd3,   7'd4,   7'd5,   7'd5,
    7'd6,   7'd7,   7'd8,   7'd9,   7'd9,   7'd10,  7'd11,  7'd12,
    7'd12,  7'd13,  7'd14,  7'd15,  7'd16,  7'd16,  7'd17,  7'd18,
    7'd19,  7'd19,  7'd20,  7'd21,  7'd22,  7'd22,  7'd23,  7'd24,
    7'd25,  7'd26,  7'd26,  7'd27,  7'd28,  7'd29,  7'd29,  7'd30,
    7'd31,  7'd32,  7'd32,  7'd33,  7'd34,  7'd35,  7'd35,  7'd36,
    7'd37,  7'd38,  7'd38,  7'd39,  7'd40,  7'd41,  7'd41,  7'd42,
    7'd43,  7'd44,  7'd44,  7'd45,  7'd46,  7'd46,  7'd47,  7'd48,
    7'd49,  7'd49,  7'd50,  7'd51,  7'd51,  7'd52,  7'd53,  7'd54,
    7'd54,  7'd55,  7'd56,  7'd56,  7'd57,  7'd58,  7'd58,  7'd59,
    7'd60,  7'd61,  7'd61,  7'd62,  7'd63,  7'd63,  7'd64,  7'd65,
    7'd65,  7'd66,  7'd67,  7'd67,  7'd68,  7'd69,  7'd69,  7'd70,
    7'd71,  7'd71,  7'd72,  7'd72,  7'd73,  7'd74,  7'd74,  7'd75,
    7'd76,  7'd76,  7'd77,  7'd78,  7'd78,  7'd79,  7'd79,  7'd80,
    7'd81,  7'd81,  7'd82,  7'd82,  7'd83,  7'd84,  7'd84,  7'd85,
    7'd85,  7'd86,  7'd86,  7'd87,  7'd88,  7'd88,  7'd89,  7'd89,
    7'd90,  7'd90,  7'd91,  7'd91,  7'd92,  7'd93,  7'd93,  7'd94,
    7'd94,  7'd95,  7'd95,  7'd96,  7'd96,  7'd97,  7'd97,  7'd98,
    7'd98,  7'd99,  7'd99,  7'd100, 7'd100, 7'd101, 7'd101, 7'd102,
    7'd102, 7'd102, 7'd103, 7'd103, 7'd104, 7'd104, 7'd105, 7'd105,
    7'd106, 7'd106, 7'd106, 7'd107, 7'd107, 7'd108, 7'd108, 7'd109,
    7'd109, 7'd109, 7'd110, 7'd110, 7'd111, 7'd111, 7'd111, 7'd112,
    7'd112, 7'd112, 7'd113, 7'd113, 7'd113, 7'd114, 7'd114, 7'd114,
    7'd115, 7'd115, 7'd115, 7'd116, 7'd116, 7'd116, 7'd117, 7'd117,
    7'd117, 7'd118, 7'd118, 7'd118, 7'd118, 7'd119, 7'd119, 7'd119,
    7'd120, 7'd120, 7'd120, 7'd120, 7'd121, 7'd121, 7'd121, 7'd121,
    7'd122, 7'd122, 7'd122, 7'd122, 7'd122, 7'd123, 7'd123, 7'd123,
    7'd123, 7'd123, 7'd124, 7'd124, 7'd124, 7'd124, 7'd124, 7'd124,
    7'd125, 7'd125, 7'd125, 7'd125, 7'd125, 7'd125, 7'd125, 7'd126,
    7'd126, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126, 7'd126,
    7'd126, 7'd126, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127,
    7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127, 7'd127
  };

  localparam logic [COARSE_W-1:0] STEP_COARSE [128] = '{
    11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd0,   11'd1,
    11'd1,   11'd1,   11'd1,   11'd1,   11'd1,   11'd1,   11'd1,   11'd1,
    11'd1,   11'd1,   11'd1,   11'd2,   11'd2,   11'd2,   11'd2,   11'd2,
    11'd2,   11'd2,   11'd3,   11'd3,   11'd3,   11'd3,   11'd3,   11'd4,
    11'd4,   11'd4,   11'd4,   11'd5,   11'd5,   11'd5,   11'd6,   11'd6,
    11'd6,   11'd7,   11'd7,   11'd8,   11'd8,   11'd9,   11'd9,   11'd10,
    11'd10,  11'd11,  11'd12,  11'd12,  11'd13,  11'd14,  11'd15,  11'd16,
    11'd17,  11'd18,  11'd19,  11'd20,  11'd21,  11'd22,  11'd24,  11'd25,
    11'd27,  11'd28,  11'd30,  11'd32,  11'd34,  11'd36,  11'd38,  11'd40,
    11'd42,  11'd45,  11'd48,  11'd50,  11'd54,  11'd57,  11'd60,  11'd64,
    11'd68,  11'd72,  11'd76,  11'd80,  11'd85,  11'd90,  11'd96,  11'd101,
    11'd108, 11'd114, 11'd121, 11'd128, 11'd136, 11'd144, 11'd152, 11'd161,
    11'd171, 11'd181, 11'd192, 11'd203, 11'd216, 11'd228, 11'd242, 11'd256,
    11'd272, 11'd288, 11'd305, 11'd323, 11'd342, 11'd363, 11'd384, 11'd407,
    11'd432, 11'd457, 11'd484, 11'd513, 11'd544, 11'd576, 11'd611, 11'd647,
    11'd685, 11'd726, 11'd769, 11'd815, 11'd864, 11'd915, 11'd969, 11'd1027
  };

  localparam logic [FRAC_W-1:0] STEP_FINE [128] = '{
    8'd171, 8'd182, 8'd192, 8'd204, 8'd216, 8'd229, 8'd242, 8'd1,
    8'd16,  8'd32,  8'd50,  8'd68,  8'd87,  8'd107, 8'd129, 8'd152,
    8'd176, 8'd202, 8'd229, 8'd2,   8'd32,  8'd65,  8'd99,  8'd135,
    8'd174, 8'd215, 8'd2,   8'd48,  8'd96,  8'd147, 8'd202, 8'd4,
    8'd65,  8'd129, 8'd198, 8'd15,  8'd92,  8'd173, 8'd4,   8'd95,
    8'd192, 8'd39,  8'd148, 8'd7,   8'd129, 8'd3,   8'd140, 8'd29,
    8'd183, 8'd90,  8'd7,   8'd190, 8'd128, 8'd78,  8'd40,  8'd14,
    8'd3,   8'd6,   8'd24,  8'd59,  8'd111, 8'd181, 8'd15,  8'd125,
    8'd1,   8'd156, 8'd79,  8'd29,  8'd6,   8'd11,  8'd48,  8'd117,
    8'd221, 8'd106, 8'd29,  8'd250, 8'd2,   8'd56,  8'd159, 8'd57,
    8'd11,  8'd23,  8'd96,  8'd235, 8'd187, 8'd212, 8'd58,  8'd243,
    8'd3,   8'd111, 8'd61,  8'd115, 8'd22,  8'd46,  8'd193, 8'd214,
    8'd117, 8'd168, 8'd117, 8'd230, 8'd6,   8'd223, 8'd123, 8'd230,
    8'd45,  8'd92,  8'd129, 8'd172, 8'd235, 8'd79,  8'd234, 8'd205,
    8'd13,  8'd190, 8'd246, 8'd204, 8'd89,  8'd184, 8'd3,   8'd88,
    8'd214, 8'd158, 8'd211, 8'd154, 8'd25,  8'd123, 8'd235, 8'd152
  };

endpackage

FILE: design/ntso_sine.sv
// Quarter-wave sine lookup: integer phase in, unsigned sample out.
// Folds the quadrant onto the quarter table; uses ntso_pkg.
module ntso_sine
  import ntso_pkg::*;
(
  input  logic [PINT_W-1:0] phase_int,
  output logic [SAMP_W-1:0] sample
);

  logic [1:0]        quad;
  logic [FRAC_W-1:0] offs;
  logic [FRAC_W-1:0] idx;
  logic [MAG_W-1:0]  mag;

  assign quad = phase_int[PINT_W-1 -: 2];
  assign offs = phase_int[FRAC_W-1:0];
  // mirror the index on odd quadrants: 255 - offset
  assign idx  = quad[0] ? ~offs : offs;
  assign mag  = QUARTER_ROM[idx];

  always_comb begin
    if (quad[1]) begin
      sample = MIDPOINT - {1'b0, mag};
    end else begin
      sample = MIDPOINT + {1'b0, mag};
    end
  end

endmodule

FILE: design/ntso_phase.sv
// Phase accumulator with per-note tuning word lookup.
// Advances by coarse*256 + fine, wrapping at 2^18; uses ntso_pkg.
module ntso_phase
  import ntso_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [NOTE_W-1:0] note_number,
  output logic [PINT_W-1:0] phase_int
);

  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [PHASE_W-1:0] tuning;
  logic [COARSE_W+FRAC_W-1:0] tuning_full;

  assign tuning_full = {STEP_COARSE[note_number], STEP_FINE[note_number]};
  // coarse steps of 1024 and up alias: drop the bit above the phase width
  assign tuning      = tuning_full[PHASE_W-1:0];
  assign phase_next  = phase + tuning;
  assign phase_int   = phase[PHASE_W-1:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (advance) begin
      phase <= phase_next;
    end
  end

endmodule

FILE: design/note_tuned_sine_oscillator_unit.sv
// Top level of the note-tuned sine oscillator: input register, sine lookup
// and phase advance, output register. Uses ntso_pkg, ntso_phase, ntso_sine.
//
//  port group     dir  tdata (low bit up)       tuser
//  s_axis_*       in   note_number[6:0], 0 pad  rest
//  m_axis_*       out  sample[7:0]              -
//
// One word per cycle sustained while m_axis does not stall. An accepted
// word passes the input register, then the output register, to m_axis.
// The sine lookup and the phase add sit between those two registers. rst
// (synchronous) clears both valid flags and the phase. When m_axis stalls,
// both stages hold and s_axis stays ready while the input stage is empty.
module note_tuned_sine_oscillator_unit
  import ntso_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [6:0] note_number, [7] zero
  input  logic        s_axis_tuser,   // [0] rest
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [7:0] sample
);

  logic              in_valid;
  logic [NOTE_W-1:0] in_note;
  logic              in_rest;
  logic              out_valid;
  logic [SAMP_W-1:0] out_sample;

  logic              out_free;
  logic              move;
  logic [PINT_W-1:0] phase_int;
  logic [SAMP_W-1:0] sine_sample;

  assign out_free      = !out_valid || m_axis_tready;
  assign move          = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  ntso_phase u_phase (
    .clk         (clk),
    .rst         (rst),
    .advance     (move && !in_rest),
    .note_number (in_note),
    .phase_int   (phase_int)
  );

  ntso_sine u_sine (
    .phase_int (phase_int),
    .sample    (sine_sample)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_note <= s_axis_tdata[NOTE_W-1:0];
      in_rest <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
  end

  // rest words give the midpoint and leave the phase alone
  always_ff @(posedge clk) begin
    if (move) begin
      out_sample <= in_rest ? MIDPOINT : sine_sample;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_sample;

endmodule

FILE: verif/tb_note_tuned_sine_oscillator_unit.sv
// Self-checking testbench for note_tuned_sine_oscillator_unit.
// Drives note/rest words, predicts each sine sample with a phase model built on
// the ntso_pkg tables, and checks results in order. Depends on ntso_pkg and the RTL.
module tb_note_tuned_sine_oscillator_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ntso_pkg::*;

  localparam int RANDOM_WORDS  = 1100;
  localparam int STEADY_WORDS  = 150;   // final stretch with no idling
  localparam int STALL_LIMIT   = 500;   // cycles with no word moving
  localparam int DRAIN_CYCLES  = 10;
  localparam int PRINT_LIMIT   = 32;

  typedef enum logic [1:0] {CHECK_OK, CHECK_MISMATCH, CHECK_STRAY} check_t;

  class sample_scoreboard;
    logic [PHASE_W-1:0] phase;
    logic [SAMP_W-1:0]  expected_samples[$];

    function void clear();
      phase = '0;
      expected_samples.delete();
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    // Predict the sample for one accepted word and advance the phase unless it is a rest.
    function void note_word(logic [NOTE_W-1:0] note, logic rest);
      logic [1:0]         quad;
      logic [7:0]         offs;
      logic [MAG_W-1:0]   mag;
      logic [PHASE_W:0]   step;
      if (rest) begin
        expected_samples.push_back(MIDPOINT);
        return;
      end
      quad = phase[PHASE_W-1 -: 2];
      offs = phase[FRAC_W +: 8];
      // odd quadrants read the table mirrored, upper half goes below midpoint
      mag = quad[0] ? QUARTER_ROM[8'hFF - offs] : QUARTER_ROM[offs];
      expected_samples.push_back(quad[1] ? MIDPOINT - {1'b0, mag} : MIDPOINT + {1'b0, mag});
      step = {STEP_COARSE[note], STEP_FINE[note]};
      phase = phase + step[PHASE_W-1:0];
    endfunction

    function check_t check_sample(logic [SAMP_W-1:0] got, output logic [SAMP_W-1:0] want);
      want = '0;
      if (expected_samples.size() == 0) return CHECK_STRAY;
      want = expected_samples.pop_front();
      return (got === want) ? CHECK_OK : CHECK_MISMATCH;
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [6:0] note_number, [7] zero
  logic       s_axis_tuser;   // [0] rest
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [7:0] sample

  sample_scoreboard sb;
  int  errors;
  int  quiet_cycles;
  bit  steady;
  int  results_seen;

  note_tuned_sine_oscillator_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(string what, logic [SAMP_W-1:0] want, logic [SAMP_W-1:0] got);
    if (errors < PRINT_LIMIT)
      $display("ERROR result %0d: %s, expected sample %0d, got %0d",
               results_seen, what, want, got);
    errors++;
  endtask

  // Present one word, idling first now and then, and hold it until taken.
  task automatic send_word(logic [NOTE_W-1:0] note, logic rest);
    if (!steady && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, note};
    s_axis_tuser  <= rest;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_word(note, rest);
  endtask

  // Play a run of one note with the odd rest and the odd random note mixed in.
  task automatic play_run(logic [NOTE_W-1:0] note, int len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_word(NOTE_W'($urandom_range(0, 127)), 1'b0);
      else
        send_word(note, $urandom_range(0, 7) == 0);
    end
  endtask

  // Result side: stall in random bursts until the final stretch.
  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      if (!steady && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    logic [SAMP_W-1:0] want;
    check_t verdict;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      verdict = sb.check_sample(m_axis_tdata, want);
      if (verdict == CHECK_STRAY)
        report("result with nothing expected", want, m_axis_tdata);
      else if (verdict == CHECK_MISMATCH)
        report("sample mismatch", want, m_axis_tdata);
      results_seen++;
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR watchdog: no word moved for %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int sent;
    int len;
    logic [NOTE_W-1:0] note;
    sb = new;
    sb.clear();
    errors       = 0;
    results_seen = 0;
    quiet_cycles = 0;
    steady       = 1'b0;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: rest straight after reset ignores the note, then extremes.
    send_word(7'd127, 1'b1);
    send_word(7'd0,   1'b0);
    send_word(7'd0,   1'b0);
    send_word(7'd0,   1'b1);
    send_word(7'd0,   1'b1);
    // Top note steps past the whole phase range and aliases.
    repeat (6) send_word(7'd127, 1'b0);
    send_word(7'd127, 1'b1);
    send_word(7'h55, 1'b0);
    send_word(7'h2A, 1'b0);
    send_word(7'd64, 1'b0);
    send_word(7'd103, 1'b0);
    repeat (4) send_word(7'd120, 1'b0);
    send_word(7'd1, 1'b1);

    // Random: runs of one note, often a high one, move the phase on.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      if (sent >= RANDOM_WORDS - STEADY_WORDS) steady = 1'b1;
      note = ($urandom_range(0, 2) == 0) ? NOTE_W'($urandom_range(96, 127))
                                         : NOTE_W'($urandom_range(0, 127));
      len = $urandom_range(1, 48);
      if (len > RANDOM_WORDS - sent) len = RANDOM_WORDS - sent;
      play_run(note, len);
      sent += len;
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: note_tuned_sine_oscillator_unit.f
design/ntso_pkg.sv
design/ntso_sine.sv
design/ntso_phase.sv
design/note_tuned_sine_oscillator_unit.sv
verif/tb_note_tuned_sine_oscillator_unit.sv
